### hdl/sdsf_pkg.sv
// Package for the soft drop shadow filter: sizes, register indexes, request codes.
// No dependencies.
package sdsf_pkg;
  localparam int MaxWidth = 512;
  localparam int MaxHeight = 512;
  localparam int MaxSoftness = 20;
  localparam int MaxShift = 30;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int AW = XW + YW;
  localparam int DimW = $clog2(MaxWidth > MaxHeight ? MaxWidth : MaxHeight) + 1;
  localparam int SW = 5;
  localparam int RowW = $clog2(2 * MaxSoftness + 1);
  localparam int NW = $clog2((2 * MaxSoftness + 1) * (2 * MaxSoftness + 1) + 1);

  localparam logic [2:0] RegStrength = 3'd0;
  localparam logic [2:0] RegSoftness = 3'd1;
  localparam logic [2:0] RegShiftX = 3'd2;
  localparam logic [2:0] RegShiftY = 3'd3;
  localparam logic [2:0] RegWidth = 3'd4;
  localparam logic [2:0] RegHeight = 3'd5;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncEmit = 1'b1;

  typedef struct packed {
    logic [7:0] strength;
    logic [SW-1:0] radius;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } cfg_t;

  // half width of disk row dy for radius s
  function automatic logic [SW-1:0] row_span(input logic [SW-1:0] s, input logic [SW:0] dyabs);
    logic [SW-1:0] hh;
    int lim;
    lim = int'(s) * int'(s) + int'(s);
    hh = '0;
    for (int k = 1; k <= MaxSoftness; k++) begin
      if (k * k + int'(dyabs) * int'(dyabs) <= lim) hh = SW'(k);
    end
    return hh;
  endfunction
endpackage

### hdl/sdsf_cfg.sv
// Configuration registers with saturation and disk scale computation.
// Depends on sdsf_pkg.
module sdsf_cfg (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data,
  output sdsf_pkg::cfg_t cfg,
  output logic [15:0] scale,
  output logic busy
);
  import sdsf_pkg::*;
  logic [7:0] str_r;
  logic [4:0] soft_r;
  logic [5:0] sx_r, sy_r;
  logic [9:0] w_r, h_r;
  logic [RowW-1:0] row_r;
  logic [11:0] area_r;
  logic [15:0] rem_r, q_r;
  logic [1:0] ph_r;
  logic [SW-1:0] s_eff;
  logic [SW:0] dyabs;

  assign cfg_ready = 1'b1;
  assign s_eff = (soft_r > SW'(MaxSoftness)) ? SW'(MaxSoftness) : soft_r;
  assign dyabs = (RowW'(row_r) >= RowW'(s_eff)) ? (SW+1)'(row_r) - (SW+1)'(s_eff)
                                               : (SW+1)'(s_eff) - (SW+1)'(row_r);

  function automatic logic signed [7:0] sat_shift(input logic [5:0] v);
    logic signed [7:0] t;
    t = 8'(signed'(v));
    if (t > 8'sd30) t = 8'(MaxShift);
    if (t < -8'sd30) t = -8'(MaxShift);
    return t;
  endfunction

  function automatic logic [DimW-1:0] sat_dim(input logic [9:0] v, input int m);
    if (v == 10'd0) return DimW'(1);
    if (int'(v) > m) return DimW'(m);
    return DimW'(v);
  endfunction

  always_comb begin
    cfg.strength = str_r;
    cfg.radius = s_eff;
    cfg.sx = sat_shift(sx_r);
    cfg.sy = sat_shift(sy_r);
    cfg.w = sat_dim(w_r, MaxWidth);
    cfg.h = sat_dim(h_r, MaxHeight);
  end
  assign scale = q_r;
  assign busy = ph_r != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_r <= 8'd128; soft_r <= 5'd2; sx_r <= 6'd5; sy_r <= 6'd5;
      w_r <= 10'd512; h_r <= 10'd512;
      ph_r <= 2'd1; row_r <= '0; area_r <= '0; rem_r <= '0; q_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegStrength: str_r <= cfg_data[7:0];
          RegSoftness: begin
            soft_r <= cfg_data[4:0]; ph_r <= 2'd1; row_r <= '0; area_r <= '0;
          end
          RegShiftX: sx_r <= cfg_data[5:0];
          RegShiftY: sy_r <= cfg_data[5:0];
          RegWidth: w_r <= cfg_data;
          RegHeight: h_r <= cfg_data;
          default: ;
        endcase
      end else if (ph_r == 2'd1) begin
        area_r <= area_r + 12'({row_span(s_eff, dyabs), 1'b1});
        if (row_r == RowW'({s_eff, 1'b0})) begin
          ph_r <= 2'd2; rem_r <= 16'hffff; q_r <= '0;
        end else row_r <= row_r + 1'b1;
      end else if (ph_r == 2'd2) begin
        if (rem_r >= 16'(area_r)) begin
          rem_r <= rem_r - 16'(area_r); q_r <= q_r + 1'b1;
        end else ph_r <= 2'd0;
      end
    end
  end
endmodule

### hdl/sdsf_store.sv
// Frame memory: 24-bit colour plus foreground bit, registered read port.
// Depends on sdsf_pkg.
module sdsf_store (
  input  logic clk,
  input  logic we,
  input  logic [sdsf_pkg::AW-1:0] waddr,
  input  logic [24:0] wdata,
  input  logic [sdsf_pkg::AW-1:0] raddr,
  output logic [24:0] rdata
);
  import sdsf_pkg::*;
  logic [24:0] mem [0:(1<<AW)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/sdsf_engine.sv
// Request sequencer: loads pixels, sweeps the disk for background pixels.
// Depends on sdsf_pkg, sdsf_store.
module sdsf_engine (
  input  logic clk,
  input  logic rst_n,
  input  sdsf_pkg::cfg_t cfg,
  input  logic [15:0] scale,
  input  logic cfg_busy,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [24:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [23:0] out_tdata,
  output logic out_tlast
);
  import sdsf_pkg::*;
  localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StPix = 3'd2, StSweep = 3'd3,
                         StMul1 = 3'd4, StMul2 = 3'd5, StOut = 3'd6, StDiv = 3'd7;
  logic [2:0] st_r;
  logic [24:0] key_r;
  logic [AW:0] lpos_r, epos_r, pos_r;
  logic [XW:0] x_r;
  logic [YW:0] y_r;
  logic [AW:0] dq_r;
  logic [XW:0] dr_r;
  logic [4:0] dcnt_r;
  logic [RowW-1:0] row_r;
  logic signed [11:0] sxc_r;
  logic [SW-1:0] hh_r;
  logic [NW-1:0] n_r;
  logic [NW+7:0] p1_r;
  logic [23:0] odata_r;
  logic olast_r, ovalid_r, last_r, smp_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [24:0] wdata, rdata;
  logic [AW:0] total, lp, ep;
  logic signed [11:0] sy, cx, sxe;
  logic [NW+23:0] p2;
  logic [XW+1:0] dsh;
  logic dge, pass, ofree, ofire;

  assign total = (AW+1)'(cfg.w) * (AW+1)'(cfg.h);
  assign lp = (lpos_r >= total) ? '0 : lpos_r;
  assign ep = (epos_r >= total) ? '0 : epos_r;
  assign in_tready = (st_r == StIdle) && !cfg_busy;
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

  // position to column and row, one quotient bit a cycle
  assign dsh = {dr_r, dq_r[AW]};
  assign dge = dsh >= (XW+2)'(cfg.w);

  assign pass = (cfg.strength == 8'd0) || rdata[24];
  assign ofree = !ovalid_r || out_tready;
  assign ofire = (st_r == StPix && pass && ofree) || (st_r == StOut);

  assign sy = 12'(signed'({1'b0, y_r})) - 12'(cfg.sy) + 12'(row_r) - 12'(cfg.radius);
  assign cx = 12'(signed'({1'b0, x_r})) - 12'(cfg.sx);
  assign sxe = cx + 12'(hh_r);
  assign p2 = (NW+24)'(p1_r) * (NW+24)'(scale);

  always_comb begin
    we = 1'b0; waddr = lp[AW-1:0];
    wdata = {in_tdata[24:1] != (lp == '0 ? in_tdata[24:1] : key_r[24:1]), in_tdata[24:1]};
    if (in_tvalid && in_tready && in_tdata[0] == FuncLoad) we = 1'b1;
    raddr = pos_r[AW-1:0];
    if (st_r == StSweep)
      raddr = AW'((AW+1)'(sy[YW-1:0]) * (AW+1)'(cfg.w) + (AW+1)'(sxc_r[XW-1:0]));
  end

  sdsf_store u_store (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; key_r <= '0; lpos_r <= '0; epos_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (ofire) ovalid_r <= 1'b1;
      else if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        StIdle: if (in_tvalid && in_tready) begin
          if (in_tdata[0] == FuncLoad) begin
            if (lp == '0) begin key_r <= in_tdata; epos_r <= '0; end
            lpos_r <= lp + 1'b1;
          end else begin
            pos_r <= ep; last_r <= (ep + 1'b1 == total);
            epos_r <= (ep + 1'b1 == total) ? '0 : ep + 1'b1;
            dq_r <= ep; dr_r <= '0; dcnt_r <= '0;
            st_r <= StDiv;
          end
        end
        StDiv: begin
          dq_r <= {dq_r[AW-1:0], dge};
          dr_r <= (XW+1)'(dge ? dsh - (XW+2)'(cfg.w) : dsh);
          if (dcnt_r == 5'(AW)) st_r <= StRead;
          else dcnt_r <= dcnt_r + 1'b1;
        end
        StRead: begin
          x_r <= dr_r;
          y_r <= (YW+1)'(dq_r);
          st_r <= StPix;
        end
        StPix: begin
          n_r <= '0; row_r <= '0; smp_r <= 1'b0;
          hh_r <= row_span(cfg.radius, (SW+1)'(cfg.radius));
          sxc_r <= cx - 12'(row_span(cfg.radius, (SW+1)'(cfg.radius)));
          if (pass) begin
            if (ofree) begin
              odata_r <= {rdata[7:0], rdata[15:8], rdata[23:16]};
              olast_r <= last_r;
              st_r <= StIdle;
            end
          end else st_r <= StSweep;
        end
        StSweep: begin
          if (smp_r) n_r <= n_r + NW'(rdata[24]);
          smp_r <= (sy >= 0) && (sy < 12'(cfg.h)) && (sxc_r >= 0) && (sxc_r < 12'(cfg.w));
          if (sxc_r >= sxe) begin
            if (row_r == RowW'({cfg.radius, 1'b0})) st_r <= StMul1;
            else begin
              row_r <= row_r + 1'b1;
              hh_r <= row_span(cfg.radius, ((row_r + 1'b1) >= RowW'(cfg.radius))
                ? (SW+1)'(row_r + 1'b1) - (SW+1)'(cfg.radius)
                : (SW+1)'(cfg.radius) - (SW+1)'(row_r + 1'b1));
              sxc_r <= cx - 12'(row_span(cfg.radius, ((row_r + 1'b1) >= RowW'(cfg.radius))
                ? (SW+1)'(row_r + 1'b1) - (SW+1)'(cfg.radius)
                : (SW+1)'(cfg.radius) - (SW+1)'(row_r + 1'b1)));
            end
          end else sxc_r <= sxc_r + 1'b1;
        end
        StMul1: begin
          if (smp_r) begin
            p1_r <= (NW+8)'(n_r + NW'(rdata[24])) * (NW+8)'(cfg.strength);
          end else p1_r <= (NW+8)'(n_r) * (NW+8)'(cfg.strength);
          st_r <= StMul2;
        end
        StMul2: begin
          if (ofree) begin
            odata_r <= {3{8'(8'd255 - 8'(p2 >> 16))}};
            olast_r <= last_r;
            st_r <= StOut;
          end
        end
        StOut: st_r <= StIdle;
        default: st_r <= StIdle;
      endcase
    end
  end
endmodule

### hdl/soft_drop_shadow_filter.sv
// An emit converts its position to column and row and reads the pixel; a foreground or
// pass-through pixel goes straight out, while a shadowed background emit sweeps the disk
// through the single frame memory read port, one disk cell a cycle. The next request is
// taken once the engine is idle; a pending result stalls only the next emit's output.
// Reset (rst_n, synchronous) restores register defaults and rebuilds the disk scale
// (also after a softness write); requests are held off meanwhile.
module soft_drop_shadow_filter (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [31:0] in_tdata, // func, red_in, green_in, blue_in, zero pad
  output logic out_tvalid,
  input  logic out_tready,
  output logic [23:0] out_tdata, // red_out, green_out, blue_out
  output logic out_tlast, // frame_end
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_data
);
  import sdsf_pkg::*;
  cfg_t cfg;
  logic [15:0] scale;
  logic busy;
  sdsf_cfg u_cfg (.clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
                  .cfg, .scale, .busy);
  sdsf_engine u_eng (.clk, .rst_n, .cfg, .scale, .cfg_busy(busy), .in_tvalid, .in_tready,
    .in_tdata({in_tdata[8:1], in_tdata[16:9], in_tdata[24:17], in_tdata[0]}),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);
  logic unused;
  assign unused = ^in_tdata[31:25];
endmodule

### hdl/sdsf_checker.sv
// Port checker for soft_drop_shadow_filter, bound to the top level.
// Depends on sdsf_pkg.
module sdsf_checker (
  input logic clk, input logic rst_n,
  input logic in_tvalid, input logic in_tready, input logic [31:0] in_tdata,
  input logic out_tvalid, input logic out_tready, input logic out_tlast
);
  import sdsf_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out dropped");
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[0] == FuncLoad) && !out_tvalid |=> !out_tvalid)
    else $error("load made output");
  a_last_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tlast)) else $error("tlast changed");
endmodule
bind soft_drop_shadow_filter sdsf_checker u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
  .in_tdata, .out_tvalid, .out_tready, .out_tlast);
